// ----- hdl/assert_macros.svh -----
// Assertion helpers, included by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside of reset.
`define CTD_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define CTD_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- hdl/ctd_pkg.sv -----
package ctd_pkg;

   // Widths that cover the full range of the table depth (up to 256 entries).
   localparam int IDX_W = 8;
   localparam int CNT_W = 9;

   localparam logic [7:0] FRAME_COMMAND = 8'hC0;
   localparam logic [7:0] FRAME_QUERY   = 8'hC1;
   localparam logic [7:0] SUB_COUNT     = 8'h00;
   localparam logic [7:0] SUB_INFO      = 8'h01;
   localparam logic [5:0] DATA_HEADER   = 6'd3;

   typedef enum logic [1:0] {
      ACT_REGISTER = 2'd0,
      ACT_FRAME    = 2'd1,
      ACT_LOCATE   = 2'd2,
      ACT_NONE     = 2'd3
   } action_type;

   typedef enum logic [3:0] {
      KIND_IGNORED    = 4'd0,
      KIND_REGISTERED = 4'd1,
      KIND_FULL       = 4'd2,
      KIND_MATCHED    = 4'd3,
      KIND_NO_MATCH   = 4'd4,
      KIND_COUNT      = 4'd5,
      KIND_INFO       = 4'd6,
      KIND_LOCATED    = 4'd7,
      KIND_BAD_INDEX  = 4'd8
   } kind_type;

   typedef enum logic {
      OP_LOOKUP = 1'b0,
      OP_LOCATE = 1'b1
   } op_type;

   // Search token that walks the cell chain one cell per cycle.
   typedef struct packed {
      logic              valid;
      op_type            op;
      logic [23:0]       id;
      logic [IDX_W-1:0]  sel;
      logic              found;
      logic [IDX_W-1:0]  idx;
      logic [31:0]       types;
   } token_type;

   // Broadcast write into the cell whose index matches addr.
   typedef struct packed {
      logic              en;
      logic [IDX_W-1:0]  addr;
      logic [23:0]       id;
      logic [31:0]       types;
   } write_type;

   function automatic logic [3:0] code_size(logic [3:0] code);
      logic [3:0] size;
      case (code)
         4'd1, 4'd2:        size = 4'd1;
         4'd3, 4'd4:        size = 4'd2;
         4'd5, 4'd6, 4'd7:  size = 4'd4;
         4'd8, 4'd9, 4'd10: size = 4'd8;
         default:           size = 4'd0;
      endcase
      return size;
   endfunction

   // Sum of slot sizes, stopping at the first code zero.
   function automatic logic [6:0] total_len(logic [31:0] t, logic [3:0] slots);
      logic [6:0] sum;
      logic       stop;
      sum  = '0;
      stop = 1'b0;
      for (int i = 0; i < 8; i++) begin
         if (4'(i) < slots && !stop) begin
            if (t[4*i +: 4] == 4'd0) begin
               stop = 1'b1;
            end else begin
               sum = sum + {3'b000, code_size(t[4*i +: 4])};
            end
         end
      end
      return sum;
   endfunction

   // Offset within frame data: header plus every slot before psel.
   function automatic logic [5:0] param_off(logic [31:0] t, logic [2:0] psel);
      logic [5:0] sum;
      sum = DATA_HEADER;
      for (int i = 0; i < 8; i++) begin
         if (3'(i) < psel) begin
            sum = sum + {2'b00, code_size(t[4*i +: 4])};
         end
      end
      return sum;
   endfunction

   function automatic logic [3:0] slot_size(logic [31:0] t, logic [2:0] psel);
      logic [31:0] shifted;
      shifted = t >> {psel, 2'b00};
      return code_size(shifted[3:0]);
   endfunction

endpackage

// ----- hdl/ctd_if.sv -----
interface ctd_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [7:0]  frame_id;
   logic [7:0]  byte_zero;
   logic [7:0]  byte_one;
   logic [7:0]  byte_two;
   logic [31:0] type_codes;
   logic [3:0]  entry_select;
   logic [2:0]  param_select;

   modport source (output valid, action, frame_id, byte_zero, byte_one, byte_two,
                   type_codes, entry_select, param_select, input ready);
   modport sink (input valid, action, frame_id, byte_zero, byte_one, byte_two,
                 type_codes, entry_select, param_select, output ready);
endinterface

interface ctd_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  kind;
   logic [3:0]  entry_index;
   logic [4:0]  entry_count;
   logic [6:0]  total_length;
   logic [5:0]  param_offset;
   logic [3:0]  param_length;
   logic [15:0] queried_index;

   modport source (output valid, kind, entry_index, entry_count, total_length,
                   param_offset, param_length, queried_index, input ready);
   modport sink (input valid, kind, entry_index, entry_count, total_length,
                 param_offset, param_length, queried_index, output ready);
endinterface

// ----- hdl/ctd_cell.sv -----
module ctd_cell #(
   parameter int CELL_INDEX  = 0,
   parameter int PARAM_SLOTS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  ctd_pkg::write_type wr,
   input  ctd_pkg::token_type tok_in,
   input  logic [ctd_pkg::CNT_W-1:0] count,
   output ctd_pkg::token_type tok_out
);
   import ctd_pkg::*;

   localparam int TW = 4 * PARAM_SLOTS;

   logic [23:0]   id_ff;
   logic [TW-1:0] types_ff;
   token_type     tok_ff;
   token_type     tok_in_next;
   logic          live;
   logic          hit;
   logic [TW+31:0] types_ext;

   always_ff @(posedge clock) begin
      if (wr.en && wr.addr == IDX_W'(CELL_INDEX)) begin
         id_ff    <= wr.id;
         types_ff <= wr.types[TW-1:0];
      end
   end

   assign live      = CNT_W'(CELL_INDEX) < count;
   assign types_ext = {32'd0, types_ff};

   always_comb begin
      if (tok_in.op == OP_LOOKUP) begin
         hit = tok_in.valid && !tok_in.found && live && (id_ff == tok_in.id);
      end else begin
         hit = tok_in.valid && !tok_in.found && live && (tok_in.sel == IDX_W'(CELL_INDEX));
      end
      tok_in_next = tok_in;
      if (hit) begin
         tok_in_next.found = 1'b1;
         tok_in_next.idx   = IDX_W'(CELL_INDEX);
         tok_in_next.types = types_ext[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff <= tok_in_next;
      end
   end

   assign tok_out = tok_ff;

endmodule

// ----- hdl/command_table_dispatch_top.sv -----
// Command table with a chain of MAX_COMMANDS cells, one table entry per cell.
// Register requests, count and info queries, ignored requests and out-of-range
// locate requests answer in the cycle after acceptance. A command lookup or a
// valid locate request sends a search token down the chain, one cell per cycle,
// and its response is loaded into the response register once the token leaves
// the last cell. One request is in work at a time, and the next is accepted
// once the response register is free or being drained.
`include "assert_macros.svh"

module command_table_dispatch_top #(
   parameter int MAX_COMMANDS = 16,
   parameter int PARAM_SLOTS  = 8
) (
   input  logic      clock,
   input  logic      reset,
   ctd_req_if.sink   req_port,
   ctd_rsp_if.source rsp_port
);
   import ctd_pkg::*;

   token_type        chain [0:MAX_COMMANDS];
   write_type        wr;
   token_type        launch;

   logic [CNT_W-1:0] count_ff, count_in;
   logic             busy_ff, busy_in;
   logic [2:0]       psel_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   kind_type         kind_ff, kind_in;
   logic [3:0]       eidx_ff, eidx_in;
   logic [4:0]       ecount_ff, ecount_in;
   logic [6:0]       tlen_ff, tlen_in;
   logic [5:0]       poff_ff, poff_in;
   logic [3:0]       plen_ff, plen_in;
   logic [15:0]      qidx_ff, qidx_in;

   logic             accept;
   logic             load;
   logic             bad_locate;
   token_type        tok_end;
   logic [23:0]      req_id;
   logic [IDX_W+3:0] idx_ext;

   assign req_port.ready = !busy_ff && (!rsp_valid_ff || rsp_port.ready);
   assign accept         = req_port.valid && req_port.ready;
   assign req_id         = {req_port.byte_two, req_port.byte_one, req_port.byte_zero};
   assign tok_end        = chain[MAX_COMMANDS];
   assign idx_ext        = {4'd0, tok_end.idx};

   assign bad_locate = ({{(CNT_W-4){1'b0}}, req_port.entry_select} >= count_ff)
                    || ({{(CNT_W-4){1'b0}}, req_port.entry_select} >= CNT_W'(MAX_COMMANDS))
                    || ({1'b0, req_port.param_select} >= 4'(PARAM_SLOTS));

   genvar g;
   generate
      for (g = 0; g < MAX_COMMANDS; g++) begin : g_cell
         ctd_cell #(
            .CELL_INDEX  (g),
            .PARAM_SLOTS (PARAM_SLOTS)
         ) u_cell (
            .clock   (clock),
            .reset   (reset),
            .wr      (wr),
            .tok_in  (chain[g]),
            .count   (count_ff),
            .tok_out (chain[g+1])
         );
      end
   endgenerate

   assign chain[0] = launch;

   always_comb begin
      wr          = '0;
      wr.addr     = count_ff[IDX_W-1:0];
      wr.id       = req_id;
      wr.types    = req_port.type_codes;
      launch      = '0;
      launch.op   = OP_LOOKUP;
      launch.id   = req_id;
      launch.sel  = {{(IDX_W-4){1'b0}}, req_port.entry_select};
      count_in    = count_ff;
      busy_in     = busy_ff;
      load        = 1'b0;
      kind_in     = KIND_IGNORED;
      eidx_in     = 4'd0;
      tlen_in     = 7'd0;
      poff_in     = 6'd0;
      plen_in     = 4'd0;
      qidx_in     = 16'd0;

      if (accept) begin
         load = 1'b1;
         case (action_type'(req_port.action))
            ACT_REGISTER: begin
               if (count_ff < CNT_W'(MAX_COMMANDS)) begin
                  wr.en    = 1'b1;
                  kind_in  = KIND_REGISTERED;
                  eidx_in  = count_ff[3:0];
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  kind_in = KIND_FULL;
               end
            end
            ACT_FRAME: begin
               if (req_port.frame_id == FRAME_COMMAND) begin
                  launch.valid = 1'b1;
                  busy_in      = 1'b1;
                  load         = 1'b0;
               end else if (req_port.frame_id == FRAME_QUERY) begin
                  if (req_port.byte_zero == SUB_COUNT) begin
                     kind_in = KIND_COUNT;
                  end else if (req_port.byte_zero == SUB_INFO) begin
                     kind_in = KIND_INFO;
                     qidx_in = {req_port.byte_two, req_port.byte_one};
                  end
               end
            end
            ACT_LOCATE: begin
               eidx_in = req_port.entry_select;
               if (bad_locate) begin
                  kind_in = KIND_BAD_INDEX;
               end else begin
                  launch.valid = 1'b1;
                  launch.op    = OP_LOCATE;
                  busy_in      = 1'b1;
                  load         = 1'b0;
               end
            end
            default: begin
               kind_in = KIND_IGNORED;
            end
         endcase
      end else if (tok_end.valid) begin
         // The token has passed every cell; finish the answer from what it picked up.
         load    = 1'b1;
         busy_in = 1'b0;
         if (tok_end.op == OP_LOCATE) begin
            kind_in = KIND_LOCATED;
            eidx_in = idx_ext[3:0];
            tlen_in = total_len(tok_end.types, 4'(PARAM_SLOTS));
            poff_in = param_off(tok_end.types, psel_ff);
            plen_in = slot_size(tok_end.types, psel_ff);
         end else if (tok_end.found) begin
            kind_in = KIND_MATCHED;
            eidx_in = idx_ext[3:0];
            tlen_in = total_len(tok_end.types, 4'(PARAM_SLOTS));
         end else begin
            kind_in = KIND_NO_MATCH;
         end
      end

      ecount_in = count_in[4:0];

      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         psel_ff <= req_port.param_select;
      end
      if (load) begin
         kind_ff   <= kind_in;
         eidx_ff   <= eidx_in;
         ecount_ff <= ecount_in;
         tlen_ff   <= tlen_in;
         poff_ff   <= poff_in;
         plen_ff   <= plen_in;
         qidx_ff   <= qidx_in;
      end
   end

   assign rsp_port.valid         = rsp_valid_ff;
   assign rsp_port.kind          = kind_ff;
   assign rsp_port.entry_index   = eidx_ff;
   assign rsp_port.entry_count   = ecount_ff;
   assign rsp_port.total_length  = tlen_ff;
   assign rsp_port.param_offset  = poff_ff;
   assign rsp_port.param_length  = plen_ff;
   assign rsp_port.queried_index = qidx_ff;

   `CTD_ASSERT(a_busy_blocks, busy_ff |-> !req_port.ready, "request accepted during a search")
   `CTD_ASSERT(a_end_loads, tok_end.valid |=> rsp_valid_ff, "search finished without a response")
   `CTD_ASSERT(a_count_max, count_ff <= CNT_W'(MAX_COMMANDS), "entry count beyond table depth")
   `CTD_ASSERT(a_locate_found, (tok_end.valid && tok_end.op == OP_LOCATE) |-> tok_end.found,
               "locate token left the chain without an entry")
   `CTD_ASSERT_ALWAYS(a_reset_idle, reset |=> !busy_ff && !rsp_valid_ff,
                      "control state not cleared by reset")

endmodule
